// ===== rtl/grid_feature_area_search_core_defines.svh =====
`ifndef GRID_FEATURE_AREA_SEARCH_CORE_DEFINES_SVH
`define GRID_FEATURE_AREA_SEARCH_CORE_DEFINES_SVH

// same-cycle implication
`define GFAS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("grid search check failed");

// next-cycle implication
`define GFAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("grid search check failed");

`endif

// ===== rtl/gfas_pkg.sv =====
`timescale 1ns / 1ps
package gfas_pkg;

    localparam int GRID_COLS     = 64;
    localparam int GRID_ROWS     = 48;
    localparam int MAX_POINTS    = 4096;
    localparam int CELL_CAPACITY = 16;
    localparam int MAX_MATCHES   = 64;

    localparam int NCELLS  = GRID_COLS * GRID_ROWS;
    localparam int COL_W   = $clog2(GRID_COLS);
    localparam int ROW_W   = $clog2(GRID_ROWS);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int CELL_W  = $clog2(NCELLS);
    localparam int SLOT_W  = $clog2(CELL_CAPACITY);
    localparam int FILL_W  = $clog2(CELL_CAPACITY + 1);
    localparam int SA_W    = $clog2(NCELLS * CELL_CAPACITY);
    localparam int NM_W    = $clog2(MAX_MATCHES + 1);
    localparam int FIDX_W  = 12;
    localparam int CXY_W   = 6;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_SCALE_X  = 2'd2,
        CFG_SCALE_Y  = 2'd3
    } t_cfg;

    typedef struct packed {
        t_req               kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [2:0]         octave;
        logic [14:0]        radius;
        logic [2:0]         min_level;
        logic signed [3:0]  max_level;
    } t_item;

    typedef struct packed {
        logic pop;
        logic init_done;
    } t_q_ctl;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE,
        ST_I_M0, ST_I_M1, ST_I_RND, ST_I_RD, ST_I_WR,
        ST_Q_M0, ST_Q_M1, ST_Q_M2, ST_Q_M3, ST_Q_CLAMP,
        ST_Q_CELL, ST_Q_FILL, ST_Q_SLOT, ST_Q_PT, ST_Q_TEST, ST_Q_END
    } t_state;

endpackage

// ===== rtl/gfas_front.sv =====
`timescale 1ns / 1ps
module gfas_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // x[15:0] y[31:16] octave[34:32] radius[49:35] min_level[52:50] max_level[56:53]
    input  logic [gfas_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                         i_s_axis_tuser,
    input  gfas_pkg::t_q_ctl                   i_ctl,
    output gfas_pkg::t_item                    o_item,
    output logic                               o_item_valid
);

    gfas_pkg::t_item                 r_q [gfas_pkg::QDEPTH];
    logic [gfas_pkg::QPTR_W-1:0]     r_wp, r_rp;
    logic [gfas_pkg::QCNT_W-1:0]     r_cnt;
    gfas_pkg::t_item                 in_item;
    logic                            known, push, pop;

    assign o_s_axis_tready = i_ctl.init_done &&
                             (r_cnt != gfas_pkg::QCNT_W'(gfas_pkg::QDEPTH));

    // unused request code is dropped here: no result, nothing queued
    assign known = (i_s_axis_tuser == gfas_pkg::REQ_CLEAR) ||
                   (i_s_axis_tuser == gfas_pkg::REQ_INSERT) ||
                   (i_s_axis_tuser == gfas_pkg::REQ_QUERY);
    assign push  = i_s_axis_tvalid && o_s_axis_tready && known;
    assign pop   = i_ctl.pop;

    always_comb begin
        in_item.kind      = gfas_pkg::t_req'(i_s_axis_tuser);
        in_item.x         = i_s_axis_tdata[15:0];
        in_item.y         = i_s_axis_tdata[31:16];
        in_item.octave    = i_s_axis_tdata[34:32];
        in_item.radius    = i_s_axis_tdata[49:35];
        in_item.min_level = i_s_axis_tdata[52:50];
        in_item.max_level = i_s_axis_tdata[56:53];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != '0);

endmodule

// ===== rtl/gfas_back.sv =====
`timescale 1ns / 1ps
`include "grid_feature_area_search_core_defines.svh"
module gfas_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gfas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    input  gfas_pkg::t_item                     i_item,
    input  logic                                i_item_valid,
    output gfas_pkg::t_q_ctl                    o_ctl,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gfas_pkg::FIDX_W-1:0]         o_feature_index,
    output logic                                o_found,
    output logic                                o_placed,
    output logic [gfas_pkg::CXY_W-1:0]          o_cell_x,
    output logic [gfas_pkg::CXY_W-1:0]          o_cell_y,
    output logic                                o_truncated,
    output logic                                o_last
);
    localparam int COL_W  = gfas_pkg::COL_W;
    localparam int ROW_W  = gfas_pkg::ROW_W;
    localparam int IDX_W  = gfas_pkg::IDX_W;
    localparam int CNT_W  = gfas_pkg::CNT_W;
    localparam int CELL_W = gfas_pkg::CELL_W;
    localparam int SLOT_W = gfas_pkg::SLOT_W;
    localparam int FILL_W = gfas_pkg::FILL_W;
    localparam int SA_W   = gfas_pkg::SA_W;
    localparam int NM_W   = gfas_pkg::NM_W;
    localparam int PT_W   = 35;

    localparam logic signed [14:0] COL_MAX = 15'(gfas_pkg::GRID_COLS - 1);
    localparam logic signed [14:0] ROW_MAX = 15'(gfas_pkg::GRID_ROWS - 1);

    // configuration
    logic signed [15:0] r_org_x, r_org_y;
    logic [15:0]        r_scl_x, r_scl_y;

    // control
    gfas_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]   r_point_count, n_point_count;
    logic [CELL_W-1:0]  r_clr_ptr, n_clr_ptr;
    logic               r_init_done, n_init_done;
    logic               r_out_valid, n_out_valid;
    logic               r_pend_valid, n_pend_valid;
    logic [NM_W-1:0]    r_n, n_n;
    logic               r_trunc, n_trunc;

    // payload
    gfas_pkg::t_item    r_it, n_it;
    logic signed [34:0] r_prod;
    logic signed [14:0] r_lo_x, n_lo_x, r_hi_x, n_hi_x, r_lo_y, n_lo_y;
    logic [14:0]        r_rx, n_rx;
    logic               r_nx, n_nx;
    logic               r_ins_in, n_ins_in;
    logic [COL_W-1:0]   r_x0, n_x0, r_x1, n_x1, r_ix, n_ix;
    logic [ROW_W-1:0]   r_y0, n_y0, r_y1, n_y1, r_iy, n_iy;
    logic [SLOT_W-1:0]  r_s, n_s;
    logic [FILL_W-1:0]  r_fill_cnt, n_fill_cnt;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic [gfas_pkg::FIDX_W-1:0] r_out_idx, n_out_idx;
    logic               r_out_found, n_out_found, r_out_placed, n_out_placed;
    logic [gfas_pkg::CXY_W-1:0]  r_out_cx, n_out_cx, r_out_cy, n_out_cy;
    logic               r_out_trunc, n_out_trunc, r_out_last, n_out_last;

    // memories
    logic [FILL_W-1:0]  fill_mem [gfas_pkg::NCELLS];
    logic [IDX_W-1:0]   slot_mem [gfas_pkg::NCELLS * gfas_pkg::CELL_CAPACITY];
    logic [PT_W-1:0]    pt_mem   [gfas_pkg::MAX_POINTS];
    logic [FILL_W-1:0]  r_fill_rd;
    logic [IDX_W-1:0]   r_slot_rd;
    logic [PT_W-1:0]    r_pt_rd;

    logic               fill_we, slot_we, pt_we;
    logic [CELL_W-1:0]  cell_idx, fill_addr;
    logic [FILL_W-1:0]  fill_wd;
    logic [SA_W-1:0]    slot_raddr, slot_waddr;

    // datapath
    logic signed [16:0] dx, dy;
    logic signed [17:0] mul_a;
    logic [15:0]        mul_b;
    logic signed [16:0] mul_bs;
    logic signed [34:0] mul_p;
    logic signed [34:0] ceil_sum;
    logic signed [14:0] p_floor, p_ceil;
    logic [34:0]        p_mag, rnd_sum;
    logic [14:0]        rq;
    logic               in_x, in_y, can_load, tbl_full, fits;
    logic signed [14:0] x0s, x1s, y0s, y1s;
    logic signed [16:0] ex, ey;
    logic [16:0]        ax, ay;
    logic [2:0]         pt_oc;
    logic               match, last_slot;

    assign can_load = !r_out_valid || i_ready;

    // shared 18x17 signed multiplier, operand chosen by the step
    assign dx = 17'(r_it.x) - 17'(r_org_x);
    assign dy = 17'(r_it.y) - 17'(r_org_y);
    always_comb begin
        mul_a = 18'(dx);
        mul_b = r_scl_x;
        case (r_state)
            gfas_pkg::ST_I_M1: begin
                mul_a = 18'(dy);
                mul_b = r_scl_y;
            end
            gfas_pkg::ST_Q_M0: mul_a = 18'(dx) - $signed({3'b000, r_it.radius});
            gfas_pkg::ST_Q_M1: mul_a = 18'(dx) + $signed({3'b000, r_it.radius});
            gfas_pkg::ST_Q_M2: begin
                mul_a = 18'(dy) - $signed({3'b000, r_it.radius});
                mul_b = r_scl_y;
            end
            gfas_pkg::ST_Q_M3: begin
                mul_a = 18'(dy) + $signed({3'b000, r_it.radius});
                mul_b = r_scl_y;
            end
            default: ;
        endcase
    end
    assign mul_bs = $signed({1'b0, mul_b});
    assign mul_p  = mul_a * mul_bs;

    // Q.20 cells -> floor, ceil and round half away from zero
    assign ceil_sum = r_prod + 35'sd1048575;
    assign p_floor  = 15'(r_prod >>> 20);
    assign p_ceil   = 15'(ceil_sum >>> 20);
    assign p_mag    = r_prod[34] ? 35'(-r_prod) : 35'(r_prod);
    assign rnd_sum  = p_mag + 35'd524288;
    assign rq       = rnd_sum[34:20];

    // negative coordinate is inside only if it rounds to zero
    assign in_x = r_nx ? (r_rx == '0) : (r_rx < 15'(gfas_pkg::GRID_COLS));
    assign in_y = r_prod[34] ? (rq == '0) : (rq < 15'(gfas_pkg::GRID_ROWS));

    assign x0s = r_lo_x[14] ? 15'sd0 : r_lo_x;
    assign x1s = (r_hi_x > COL_MAX) ? COL_MAX : r_hi_x;
    assign y0s = r_lo_y[14] ? 15'sd0 : r_lo_y;
    assign y1s = (p_ceil > ROW_MAX) ? ROW_MAX : p_ceil;

    assign cell_idx   = CELL_W'(r_ix) * CELL_W'(gfas_pkg::GRID_ROWS) + CELL_W'(r_iy);
    assign fill_addr  = (r_state == gfas_pkg::ST_CLR) ? r_clr_ptr : cell_idx;
    assign slot_raddr = SA_W'(cell_idx) * SA_W'(gfas_pkg::CELL_CAPACITY) + SA_W'(r_s);
    assign slot_waddr = SA_W'(cell_idx) * SA_W'(gfas_pkg::CELL_CAPACITY) + SA_W'(r_fill_rd);

    assign tbl_full = (r_point_count >= CNT_W'(gfas_pkg::MAX_POINTS));
    assign fits     = r_ins_in && (r_fill_rd < FILL_W'(gfas_pkg::CELL_CAPACITY));

    // window test on the fetched point
    assign pt_oc = r_pt_rd[34:32];
    assign ex    = 17'($signed(r_pt_rd[15:0])) - 17'(r_it.x);
    assign ey    = 17'($signed(r_pt_rd[31:16])) - 17'(r_it.y);
    assign ax    = ex[16] ? 17'(-ex) : 17'(ex);
    assign ay    = ey[16] ? 17'(-ey) : 17'(ey);
    assign match = (pt_oc >= r_it.min_level) &&
                   (r_it.max_level[3] || (pt_oc <= r_it.max_level[2:0])) &&
                   (ax < {2'b00, r_it.radius}) && (ay < {2'b00, r_it.radius});
    assign last_slot = (FILL_W'(r_s) + 1'b1) == r_fill_cnt;

    always_comb begin
        n_state       = r_state;
        n_point_count = r_point_count;
        n_clr_ptr     = r_clr_ptr;
        n_init_done   = r_init_done;
        n_out_valid   = r_out_valid && !i_ready;
        n_pend_valid  = r_pend_valid;
        n_n           = r_n;
        n_trunc       = r_trunc;
        n_it          = r_it;
        n_lo_x        = r_lo_x;
        n_hi_x        = r_hi_x;
        n_lo_y        = r_lo_y;
        n_rx          = r_rx;
        n_nx          = r_nx;
        n_ins_in      = r_ins_in;
        n_x0          = r_x0;
        n_x1          = r_x1;
        n_y0          = r_y0;
        n_y1          = r_y1;
        n_ix          = r_ix;
        n_iy          = r_iy;
        n_s           = r_s;
        n_fill_cnt    = r_fill_cnt;
        n_pend_idx    = r_pend_idx;
        n_out_idx     = r_out_idx;
        n_out_found   = r_out_found;
        n_out_placed  = r_out_placed;
        n_out_cx      = r_out_cx;
        n_out_cy      = r_out_cy;
        n_out_trunc   = r_out_trunc;
        n_out_last    = r_out_last;
        fill_we       = 1'b0;
        fill_wd       = '0;
        slot_we       = 1'b0;
        pt_we         = 1'b0;
        o_ctl.pop     = 1'b0;

        case (r_state)
            gfas_pkg::ST_CLR: begin
                fill_we   = 1'b1;
                n_clr_ptr = r_clr_ptr + 1'b1;
                if (r_clr_ptr == CELL_W'(gfas_pkg::NCELLS - 1)) begin
                    n_point_count = '0;
                    n_init_done   = 1'b1;
                    n_state       = gfas_pkg::ST_IDLE;
                end
            end
            gfas_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    o_ctl.pop = 1'b1;
                    n_it      = i_item;
                    case (i_item.kind)
                        gfas_pkg::REQ_CLEAR: begin
                            n_clr_ptr = '0;
                            n_state   = gfas_pkg::ST_CLR;
                        end
                        gfas_pkg::REQ_INSERT: n_state = gfas_pkg::ST_I_M0;
                        gfas_pkg::REQ_QUERY: begin
                            n_n          = '0;
                            n_trunc      = 1'b0;
                            n_pend_valid = 1'b0;
                            n_state      = gfas_pkg::ST_Q_M0;
                        end
                        default: ;
                    endcase
                end
            end
            gfas_pkg::ST_I_M0: n_state = gfas_pkg::ST_I_M1;
            gfas_pkg::ST_I_M1: begin
                n_rx    = rq;
                n_nx    = r_prod[34];
                n_state = gfas_pkg::ST_I_RND;
            end
            gfas_pkg::ST_I_RND: begin
                n_ins_in = in_x && in_y;
                n_ix     = (in_x && in_y && !r_nx) ? r_rx[COL_W-1:0] : '0;
                n_iy     = (in_x && in_y && !r_prod[34]) ? rq[ROW_W-1:0] : '0;
                n_state  = gfas_pkg::ST_I_RD;
            end
            gfas_pkg::ST_I_RD: n_state = gfas_pkg::ST_I_WR;
            gfas_pkg::ST_I_WR: begin
                if (can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = 1'b0;
                    n_out_trunc  = 1'b0;
                    n_out_last   = 1'b1;
                    n_out_cx     = gfas_pkg::CXY_W'(r_ix);
                    n_out_cy     = gfas_pkg::CXY_W'(r_iy);
                    n_out_idx    = '0;
                    n_out_placed = 1'b0;
                    if (!tbl_full) begin
                        pt_we         = 1'b1;
                        n_point_count = r_point_count + 1'b1;
                        n_out_idx     = gfas_pkg::FIDX_W'(r_point_count);
                        if (fits) begin
                            slot_we      = 1'b1;
                            fill_we      = 1'b1;
                            fill_wd      = r_fill_rd + 1'b1;
                            n_out_placed = 1'b1;
                        end
                    end
                    n_state = gfas_pkg::ST_IDLE;
                end
            end
            gfas_pkg::ST_Q_M0: n_state = gfas_pkg::ST_Q_M1;
            gfas_pkg::ST_Q_M1: begin
                n_lo_x  = p_floor;
                n_state = gfas_pkg::ST_Q_M2;
            end
            gfas_pkg::ST_Q_M2: begin
                n_hi_x  = p_ceil;
                n_state = gfas_pkg::ST_Q_M3;
            end
            gfas_pkg::ST_Q_M3: begin
                n_lo_y  = p_floor;
                n_state = gfas_pkg::ST_Q_CLAMP;
            end
            gfas_pkg::ST_Q_CLAMP: begin
                n_x0 = x0s[COL_W-1:0];
                n_x1 = x1s[COL_W-1:0];
                n_y0 = y0s[ROW_W-1:0];
                n_y1 = y1s[ROW_W-1:0];
                n_ix = x0s[COL_W-1:0];
                n_iy = y0s[ROW_W-1:0];
                if ((x0s > x1s) || (y0s > y1s)) begin
                    n_state = gfas_pkg::ST_Q_END;
                end else begin
                    n_state = gfas_pkg::ST_Q_CELL;
                end
            end
            gfas_pkg::ST_Q_CELL: n_state = gfas_pkg::ST_Q_FILL;
            gfas_pkg::ST_Q_FILL: begin
                n_fill_cnt = r_fill_rd;
                n_s        = '0;
                if (r_fill_rd != '0) begin
                    n_state = gfas_pkg::ST_Q_SLOT;
                end else if (r_iy != r_y1) begin
                    n_iy    = r_iy + 1'b1;
                    n_state = gfas_pkg::ST_Q_CELL;
                end else if (r_ix != r_x1) begin
                    n_ix    = r_ix + 1'b1;
                    n_iy    = r_y0;
                    n_state = gfas_pkg::ST_Q_CELL;
                end else begin
                    n_state = gfas_pkg::ST_Q_END;
                end
            end
            gfas_pkg::ST_Q_SLOT: n_state = gfas_pkg::ST_Q_PT;
            gfas_pkg::ST_Q_PT:   n_state = gfas_pkg::ST_Q_TEST;
            gfas_pkg::ST_Q_TEST: begin
                logic adv;
                adv = 1'b1;
                if (match) begin
                    if (r_n == NM_W'(gfas_pkg::MAX_MATCHES)) begin
                        n_trunc = 1'b1;
                    end else if (!r_pend_valid) begin
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_slot_rd;
                        n_n          = r_n + 1'b1;
                    end else if (can_load) begin
                        // older match goes out; the newest is held back for last
                        n_out_valid  = 1'b1;
                        n_out_idx    = gfas_pkg::FIDX_W'(r_pend_idx);
                        n_out_found  = 1'b1;
                        n_out_placed = 1'b0;
                        n_out_cx     = '0;
                        n_out_cy     = '0;
                        n_out_trunc  = 1'b0;
                        n_out_last   = 1'b0;
                        n_pend_idx   = r_slot_rd;
                        n_n          = r_n + 1'b1;
                    end else begin
                        adv = 1'b0;
                    end
                end
                if (adv) begin
                    if (!last_slot) begin
                        n_s     = r_s + 1'b1;
                        n_state = gfas_pkg::ST_Q_SLOT;
                    end else if (r_iy != r_y1) begin
                        n_iy    = r_iy + 1'b1;
                        n_state = gfas_pkg::ST_Q_CELL;
                    end else if (r_ix != r_x1) begin
                        n_ix    = r_ix + 1'b1;
                        n_iy    = r_y0;
                        n_state = gfas_pkg::ST_Q_CELL;
                    end else begin
                        n_state = gfas_pkg::ST_Q_END;
                    end
                end
            end
            gfas_pkg::ST_Q_END: begin
                if (can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_pend_valid ? gfas_pkg::FIDX_W'(r_pend_idx) : '0;
                    n_out_found  = r_pend_valid;
                    n_out_placed = 1'b0;
                    n_out_cx     = '0;
                    n_out_cy     = '0;
                    n_out_trunc  = r_pend_valid && r_trunc;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = gfas_pkg::ST_IDLE;
                end
            end
            default: n_state = gfas_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gfas_pkg::ST_CLR;
            r_point_count <= '0;
            r_clr_ptr     <= '0;
            r_init_done   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_n           <= '0;
            r_trunc       <= 1'b0;
            r_org_x       <= '0;
            r_org_y       <= '0;
            r_scl_x       <= 16'd6554;
            r_scl_y       <= 16'd6554;
        end else begin
            r_state       <= n_state;
            r_point_count <= n_point_count;
            r_clr_ptr     <= n_clr_ptr;
            r_init_done   <= n_init_done;
            r_out_valid   <= n_out_valid;
            r_pend_valid  <= n_pend_valid;
            r_n           <= n_n;
            r_trunc       <= n_trunc;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    gfas_pkg::CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                    gfas_pkg::CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                    gfas_pkg::CFG_SCALE_X:  r_scl_x <= i_cfg_data;
                    gfas_pkg::CFG_SCALE_Y:  r_scl_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_it         <= n_it;
        r_prod       <= mul_p;
        r_lo_x       <= n_lo_x;
        r_hi_x       <= n_hi_x;
        r_lo_y       <= n_lo_y;
        r_rx         <= n_rx;
        r_nx         <= n_nx;
        r_ins_in     <= n_ins_in;
        r_x0         <= n_x0;
        r_x1         <= n_x1;
        r_y0         <= n_y0;
        r_y1         <= n_y1;
        r_ix         <= n_ix;
        r_iy         <= n_iy;
        r_s          <= n_s;
        r_fill_cnt   <= n_fill_cnt;
        r_pend_idx   <= n_pend_idx;
        r_out_idx    <= n_out_idx;
        r_out_found  <= n_out_found;
        r_out_placed <= n_out_placed;
        r_out_cx     <= n_out_cx;
        r_out_cy     <= n_out_cy;
        r_out_trunc  <= n_out_trunc;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_addr] <= fill_wd;
        end
        r_fill_rd <= fill_mem[fill_addr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= r_point_count[IDX_W-1:0];
        end
        r_slot_rd <= slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[r_point_count[IDX_W-1:0]] <= {r_it.octave, r_it.y, r_it.x};
        end
        r_pt_rd <= pt_mem[r_slot_rd];
    end

    assign o_ctl.init_done  = r_init_done;
    assign o_valid          = r_out_valid;
    assign o_feature_index  = r_out_idx;
    assign o_found          = r_out_found;
    assign o_placed         = r_out_placed;
    assign o_cell_x         = r_out_cx;
    assign o_cell_y         = r_out_cy;
    assign o_truncated      = r_out_trunc;
    assign o_last           = r_out_last;

    `GFAS_ASSERT_NOW(a_match_cap, i_clk, i_rst_n, 1'b1, r_n <= NM_W'(gfas_pkg::MAX_MATCHES))
    `GFAS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_point_count <= CNT_W'(gfas_pkg::MAX_POINTS))
    `GFAS_ASSERT_NOW(a_slot_in_fill, i_clk, i_rst_n, r_state == gfas_pkg::ST_Q_TEST, FILL_W'(r_s) < r_fill_cnt)
    `GFAS_ASSERT_NEXT(a_query_ends_last, i_clk, i_rst_n, (r_state == gfas_pkg::ST_Q_END) && can_load, r_out_valid && r_out_last)

endmodule

// ===== rtl/grid_feature_area_search_core.sv =====
`timescale 1ns / 1ps
// channel   | dir | handshake                        | payload
// request   | in  | i_s_axis_tvalid/o_s_axis_tready  | tdata point fields, tuser req_type
// result    | out | o_m_axis_tvalid/i_m_axis_tready  | tdata index/cell, tuser flags, tlast
// config    | in  | i_cfg_wr_en                      | i_cfg_index, i_cfg_data
//
// Insert: pop in idle, x and y multiply, round, fill read, fill write. Query: bound
// multiplies, clamp, cell and fill per window cell, slot, point and test per slot,
// then the final beat. Clear sweeps all 3072 cells of the fill-count memory, one port
// write a cycle; after reset the same sweep runs and no request is taken until it ends.
// A 2-entry queue sits between request intake and engine; a full result register stalls
// the engine only when a new beat must go out.
module grid_feature_area_search_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // point_x[15:0] point_y[31:16] octave[34:32] radius[49:35] min_level[52:50]
    // max_level[56:53]
    input  logic [gfas_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // feature_index[11:0] cell_x[17:12] cell_y[23:18]
    output logic [gfas_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // found[0] placed[1] truncated[2]
    output logic [2:0]                          o_m_axis_tuser,
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_wr_en,
    input  logic [gfas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);

    gfas_pkg::t_item  item;
    logic             item_valid;
    gfas_pkg::t_q_ctl ctl;
    logic [gfas_pkg::FIDX_W-1:0] feature_index;
    logic [gfas_pkg::CXY_W-1:0]  cell_x, cell_y;
    logic             found, placed, truncated;

    gfas_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_ctl           (ctl),
        .o_item          (item),
        .o_item_valid    (item_valid)
    );

    gfas_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_item          (item),
        .i_item_valid    (item_valid),
        .o_ctl           (ctl),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_feature_index (feature_index),
        .o_found         (found),
        .o_placed        (placed),
        .o_cell_x        (cell_x),
        .o_cell_y        (cell_y),
        .o_truncated     (truncated),
        .o_last          (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {cell_y, cell_x, feature_index};
    assign o_m_axis_tuser = {truncated, placed, found};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import gfas_pkg::*;

    typedef struct packed {
        logic [11:0] fidx;
        logic        found;
        logic        placed;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic        trunc;
        logic        last;
    } t_hit;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_DATA_W-1:0]   i_s_axis_tdata = '0;
    logic [1:0]             i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic [2:0]             o_m_axis_tuser;
    logic                   o_m_axis_tlast;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [15:0]            i_cfg_data = '0;

    grid_feature_area_search_core u_top (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] org_x, org_y;
    logic [15:0]        scl_x, scl_y;
    logic signed [15:0] pt_x [MAX_POINTS];
    logic signed [15:0] pt_y [MAX_POINTS];
    logic [2:0]         pt_oct [MAX_POINTS];
    int                 pt_count;
    int                 fill [NCELLS];
    int                 slots [NCELLS*CELL_CAPACITY];

    t_hit   expected_hits[$];
    int     errors = 0;
    int     cycles = 0;
    int     n_items = 0, n_hits = 0, n_trunc = 0, n_unplaced = 0;
    bit     quiet = 0;

    function automatic longint fl20(longint v);
        return v >= 0 ? (v >>> 20) : -(((-v) + 64'hFFFFF) >>> 20);
    endfunction
    function automatic longint ce20(longint v);
        return v >= 0 ? ((v + 64'hFFFFF) >>> 20) : -((-v) >>> 20);
    endfunction
    function automatic longint rn20(longint v);
        return v >= 0 ? ((v + 64'h80000) >>> 20) : -(((-v) + 64'h80000) >>> 20);
    endfunction

    function automatic t_hit mk(int idx, bit f, bit p, int cx, int cy, bit t, bit l);
        t_hit h;
        h.fidx = idx[11:0]; h.found = f; h.placed = p;
        h.cx = cx[5:0]; h.cy = cy[5:0]; h.trunc = t; h.last = l;
        return h;
    endfunction

    task automatic add_expected(t_hit h);
        expected_hits = {expected_hits, h};
    endtask

    task automatic clear_store();
        pt_count = 0;
        foreach (fill[i]) fill[i] = 0;
    endtask

    task automatic predict_insert(logic signed [15:0] x, logic signed [15:0] y,
                                  logic [2:0] oct);
        longint gx, gy;
        bit     ins;
        int     cx, cy, c, idx;
        bit     placed;
        gx = rn20(longint'(int'(x) - int'(org_x)) * longint'(scl_x));
        gy = rn20(longint'(int'(y) - int'(org_y)) * longint'(scl_y));
        ins = gx >= 0 && gx < GRID_COLS && gy >= 0 && gy < GRID_ROWS;
        cx = ins ? int'(gx) : 0;
        cy = ins ? int'(gy) : 0;
        placed = 0;
        if (pt_count >= MAX_POINTS) begin
            add_expected(mk(0, 0, 0, cx, cy, 0, 1));
            n_unplaced++;
            return;
        end
        idx = pt_count;
        pt_x[idx] = x; pt_y[idx] = y; pt_oct[idx] = oct;
        pt_count++;
        if (ins) begin
            c = cx * GRID_ROWS + cy;
            if (fill[c] < CELL_CAPACITY) begin
                slots[c*CELL_CAPACITY + fill[c]] = idx;
                fill[c]++;
                placed = 1;
            end
        end
        if (!placed) n_unplaced++;
        add_expected(mk(idx, 0, placed, cx, cy, 0, 1));
    endtask

    task automatic predict_query(logic signed [15:0] qx, logic signed [15:0] qy,
                                 logic [14:0] r, logic [2:0] minl,
                                 logic signed [3:0] maxl);
        int     dx, dy, n, id, ex, ey, c, ri;
        longint x0, x1, y0, y1;
        bit     tr;
        t_hit   found_q[$];
        ri = int'(r);
        dx = int'(qx) - int'(org_x);
        dy = int'(qy) - int'(org_y);
        x0 = fl20(longint'(dx - ri) * longint'(scl_x));
        x1 = ce20(longint'(dx + ri) * longint'(scl_x));
        y0 = fl20(longint'(dy - ri) * longint'(scl_y));
        y1 = ce20(longint'(dy + ri) * longint'(scl_y));
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > GRID_COLS-1) x1 = GRID_COLS-1;
        if (y1 > GRID_ROWS-1) y1 = GRID_ROWS-1;
        n = 0; tr = 0;
        for (longint ix = x0; ix <= x1; ix++)
            for (longint iy = y0; iy <= y1; iy++) begin
                c = int'(ix) * GRID_ROWS + int'(iy);
                for (int s = 0; s < fill[c]; s++) begin
                    id = slots[c*CELL_CAPACITY + s];
                    if (int'(pt_oct[id]) < int'(minl)) continue;
                    if (maxl >= 0 && int'(pt_oct[id]) > int'(maxl)) continue;
                    ex = int'(pt_x[id]) - int'(qx);
                    ey = int'(pt_y[id]) - int'(qy);
                    if (ex < 0) ex = -ex;
                    if (ey < 0) ey = -ey;
                    if (ex < ri && ey < ri) begin
                        if (n < MAX_MATCHES) begin
                            found_q = {found_q, mk(id, 1, 0, 0, 0, 0, 0)};
                            n++;
                        end else tr = 1;
                    end
                end
            end
        if (n == 0) begin
            add_expected(mk(0, 0, 0, 0, 0, 0, 1));
            return;
        end
        found_q[n-1].trunc = tr;
        found_q[n-1].last = 1;
        if (tr) n_trunc++;
        foreach (found_q[i]) add_expected(found_q[i]);
    endtask

    task automatic report(string what, t_hit got, t_hit want);
        errors++;
        $display("ERROR %s: got idx=%0d f=%0d p=%0d c=%0d,%0d t=%0d l=%0d %s",
                 what, got.fidx, got.found, got.placed, got.cx, got.cy, got.trunc,
                 got.last,
                 $sformatf("want idx=%0d f=%0d p=%0d c=%0d,%0d t=%0d l=%0d",
                           want.fidx, want.found, want.placed, want.cx, want.cy,
                           want.trunc, want.last));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_hit got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.fidx = o_m_axis_tdata[11:0];
            got.cx = o_m_axis_tdata[17:12];
            got.cy = o_m_axis_tdata[23:18];
            got.found = o_m_axis_tuser[0];
            got.placed = o_m_axis_tuser[1];
            got.trunc = o_m_axis_tuser[2];
            got.last = o_m_axis_tlast;
            n_hits++;
            if (expected_hits.size() == 0) report("unexpected beat", got, got);
            else begin
                want = expected_hits.pop_front();
                if (got !== want) report("field mismatch", got, want);
            end
        end
    end

    // result-side backpressure
    always @(posedge i_clk) begin
        int stall;
        if (quiet) i_m_axis_tready <= 1'b1;
        else if (stall > 0) begin
            stall--;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            i_m_axis_tready <= 1'b0;
        end else i_m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 10000000) begin
            $display("timeout");
            $display("grid_feature_area_search_core: mismatch");
            $finish;
        end
    end

    task automatic send(t_req kind, logic signed [15:0] x, logic signed [15:0] y,
                        logic [2:0] oct, logic [14:0] r, logic [2:0] minl,
                        logic signed [3:0] maxl);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        case (kind)
            REQ_CLEAR:  clear_store();
            REQ_INSERT: predict_insert(x, y, oct);
            REQ_QUERY:  predict_query(x, y, r, minl, maxl);
            default: ;
        endcase
        n_items++;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= kind;
        i_s_axis_tdata <= {7'd0, maxl, minl, r, oct, y, x};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        // up to three clears may still be queued or sweeping
        repeat (3 * 3100) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg idx, logic [15:0] v);
        case (idx)
            CFG_ORIGIN_X: org_x = v;
            CFG_ORIGIN_Y: org_y = v;
            CFG_SCALE_X:  scl_x = v;
            CFG_SCALE_Y:  scl_y = v;
            default: ;
        endcase
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic rand_ins(int lo, int hi);
        int vx, vy;
        vx = int'($urandom_range(0, hi - lo)) + lo;
        vy = int'($urandom_range(0, hi - lo)) + lo;
        send(REQ_INSERT, 16'(vx), 16'(vy), 3'($urandom), 15'd0, 3'd0, 4'sd0);
    endtask

    task automatic test_directed();
        send(REQ_QUERY, 16'sd0, 16'sd0, 3'd0, 15'd32767, 3'd0, -4'sd1); // empty store
        send(REQ_INSERT, 16'sd0, 16'sd0, 3'd0, 15'd0, 3'd0, 4'sd0);
        send(REQ_INSERT, 16'sd80, 16'sd80, 3'd7, 15'd0, 3'd0, 4'sd0);     // half-way up
        send(REQ_INSERT, -16'sd80, 16'sd5, 3'd3, 15'd0, 3'd0, 4'sd0);     // negative
        send(REQ_INSERT, 16'sh7FFF, 16'sh7FFF, 3'd2, 15'd0, 3'd0, 4'sd0); // outside grid
        send(REQ_INSERT, -16'sh8000, -16'sh8000, 3'd1, 15'd0, 3'd0, 4'sd0);
        for (int i = 0; i < 17; i++)                                     // overfill a cell
            send(REQ_INSERT, 16'(1600 + i), 16'(1600), 3'(i), 15'd0, 3'd0, 4'sd0);
        send(REQ_QUERY, 16'sd1610, 16'sd1600, 3'd0, 15'd40, 3'd2, 4'sd5);
        send(REQ_QUERY, 16'sd0, 16'sd0, 3'd0, 15'd32767, 3'd0, -4'sd1);
        send(REQ_QUERY, 16'sh7FFF, -16'sh8000, 3'd0, 15'd0, 3'd7, 4'sd7);
        send(t_req'(2'd3), 16'hFFFF, 16'hFFFF, 3'd7, 15'h7FFF, 3'd7, -4'sd1); // ignored
        send(REQ_CLEAR, 16'sd0, 16'sd0, 3'd0, 15'd0, 3'd0, 4'sd0);
        send(REQ_QUERY, 16'sd1600, 16'sd1600, 3'd0, 15'd100, 3'd0, -4'sd1);
        drain();
    endtask

    task automatic test_truncation();
        for (int i = 0; i < 70; i++) rand_ins(0, 600);
        send(REQ_QUERY, 16'sd300, 16'sd300, 3'd0, 15'd400, 3'd0, -4'sd1);
        drain();
    endtask

    task automatic test_random(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 19);
            if (k == 0) send(REQ_CLEAR, 16'sd0, 16'sd0, 3'd0, 15'd0, 3'd0, 4'sd0);
            else if (k < 10) rand_ins(-200, 9000);
            else if (k < 12) send(REQ_INSERT, 16'($urandom), 16'($urandom), 3'($urandom),
                                  15'($urandom), 3'($urandom), 4'($urandom));
            else if (k < 18)
                send(REQ_QUERY, 16'($urandom_range(0, 8000)), 16'($urandom_range(0, 6000)),
                     3'($urandom), 15'($urandom_range(0, 600)),
                     3'($urandom_range(0, 3)), 4'($urandom_range(0, 9)) - 4'sd2);
            else send(REQ_QUERY, 16'($urandom), 16'($urandom), 3'($urandom),
                      15'($urandom), 3'($urandom), 4'($urandom));
        end
    endtask

    task automatic test_config();
        write_reg(CFG_ORIGIN_X, -16'sd800);
        write_reg(CFG_ORIGIN_Y, 16'sd320);
        write_reg(CFG_SCALE_X, 16'hFFFF);
        write_reg(CFG_SCALE_Y, 16'd13107);
        send(REQ_CLEAR, 16'sd0, 16'sd0, 3'd0, 15'd0, 3'd0, 4'sd0);
        test_random(20);
        drain();
        write_reg(CFG_ORIGIN_X, 16'sh7FFF);
        write_reg(CFG_ORIGIN_Y, -16'sh8000);
        write_reg(CFG_SCALE_X, 16'd0);
        write_reg(CFG_SCALE_Y, 16'd0);
        test_random(10);
        drain();
        write_reg(CFG_ORIGIN_X, 16'sd0);
        write_reg(CFG_ORIGIN_Y, 16'sd0);
        write_reg(CFG_SCALE_X, 16'd6554);
        write_reg(CFG_SCALE_Y, 16'd6554);
    endtask

    initial begin
        org_x = 0; org_y = 0; scl_x = 16'd6554; scl_y = 16'd6554;
        clear_store();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_truncation();
        test_random(12);
        drain();
        test_config();
        quiet = 1;
        test_random(20);
        drain();
        $display("covered %0d requests, %0d result beats, %0d truncated queries,",
                 n_items, n_hits, n_trunc);
        $display("%0d unfiled inserts, four register settings incl. extremes", n_unplaced);
        if (errors == 0) $display("grid_feature_area_search_core: match");
        else $display("grid_feature_area_search_core: mismatch");
        $finish;
    end
endmodule
